// ----- rtl/core/jqe_pkg.sv -----
// Package for the JPEG quality estimator core.
// Holds the controller states, the command and status structs and the reference tables.
// Depends on nothing.
`default_nettype none

package jqe_pkg;

	localparam int TABLE_SLOTS_DEF     = 4;
	localparam int COEFS_PER_TABLE_DEF = 64;

	localparam int SCAN_STEPS  = 100;
	localparam int STEP_W      = 7;
	localparam int FORCE_STEP  = 50;
	localparam int LUMA_POS_A  = 2;
	localparam int LUMA_POS_B  = 53;
	localparam int CHROMA_POS_A = 0;

	localparam int VALUE_W = 16;
	localparam int SUM_W   = 24;
	localparam int PROBE_W = 17;
	localparam int QUALITY_W = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic accumulate;
		logic prep;
		logic step_inc;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic done;
	} status_t;

	localparam logic [15:0] TWO_HASH [SCAN_STEPS] = '{
		16'd1020, 16'd1015, 16'd932, 16'd848, 16'd780, 16'd735, 16'd702, 16'd679,
		16'd660, 16'd645, 16'd632, 16'd623, 16'd613, 16'd607, 16'd600, 16'd594,
		16'd589, 16'd585, 16'd581, 16'd571, 16'd555, 16'd542, 16'd529, 16'd514,
		16'd494, 16'd474, 16'd457, 16'd439, 16'd424, 16'd410, 16'd397, 16'd386,
		16'd373, 16'd364, 16'd351, 16'd341, 16'd334, 16'd324, 16'd317, 16'd309,
		16'd299, 16'd294, 16'd287, 16'd279, 16'd274, 16'd267, 16'd262, 16'd257,
		16'd251, 16'd247, 16'd243, 16'd237, 16'd232, 16'd227, 16'd222, 16'd217,
		16'd213, 16'd207, 16'd202, 16'd198, 16'd192, 16'd188, 16'd183, 16'd177,
		16'd173, 16'd168, 16'd163, 16'd157, 16'd153, 16'd148, 16'd143, 16'd139,
		16'd132, 16'd128, 16'd125, 16'd119, 16'd115, 16'd108, 16'd104, 16'd99,
		16'd94, 16'd90, 16'd84, 16'd79, 16'd74, 16'd70, 16'd64, 16'd59,
		16'd55, 16'd49, 16'd45, 16'd40, 16'd34, 16'd30, 16'd25, 16'd20,
		16'd15, 16'd11, 16'd6, 16'd4
	};

	localparam logic [15:0] TWO_SUMS [SCAN_STEPS] = '{
		16'd32640, 16'd32635, 16'd32266, 16'd31495, 16'd30665, 16'd29804, 16'd29146,
		16'd28599, 16'd28104, 16'd27670, 16'd27225, 16'd26725, 16'd26210, 16'd25716,
		16'd25240, 16'd24789, 16'd24373, 16'd23946, 16'd23572, 16'd22846, 16'd21801,
		16'd20842, 16'd19949, 16'd19121, 16'd18386, 16'd17651, 16'd16998, 16'd16349,
		16'd15800, 16'd15247, 16'd14783, 16'd14321, 16'd13859, 16'd13535, 16'd13081,
		16'd12702, 16'd12423, 16'd12056, 16'd11779, 16'd11513, 16'd11135, 16'd10955,
		16'd10676, 16'd10392, 16'd10208, 16'd9928, 16'd9747, 16'd9564, 16'd9369,
		16'd9193, 16'd9017, 16'd8822, 16'd8639, 16'd8458, 16'd8270, 16'd8084,
		16'd7896, 16'd7710, 16'd7527, 16'd7347, 16'd7156, 16'd6977, 16'd6788,
		16'd6607, 16'd6422, 16'd6236, 16'd6054, 16'd5867, 16'd5684, 16'd5495,
		16'd5305, 16'd5128, 16'd4945, 16'd4751, 16'd4638, 16'd4442, 16'd4248,
		16'd4065, 16'd3888, 16'd3698, 16'd3509, 16'd3326, 16'd3139, 16'd2957,
		16'd2775, 16'd2586, 16'd2405, 16'd2216, 16'd2037, 16'd1846, 16'd1666,
		16'd1483, 16'd1297, 16'd1109, 16'd927, 16'd735, 16'd554, 16'd375,
		16'd201, 16'd128
	};

	localparam logic [15:0] ONE_HASH [SCAN_STEPS] = '{
		16'd510, 16'd505, 16'd422, 16'd380, 16'd355, 16'd338, 16'd326, 16'd318,
		16'd311, 16'd305, 16'd300, 16'd297, 16'd293, 16'd291, 16'd288, 16'd286,
		16'd284, 16'd283, 16'd281, 16'd280, 16'd279, 16'd278, 16'd277, 16'd273,
		16'd262, 16'd251, 16'd243, 16'd233, 16'd225, 16'd218, 16'd211, 16'd205,
		16'd198, 16'd193, 16'd186, 16'd181, 16'd177, 16'd172, 16'd168, 16'd164,
		16'd158, 16'd156, 16'd152, 16'd148, 16'd145, 16'd142, 16'd139, 16'd136,
		16'd133, 16'd131, 16'd129, 16'd126, 16'd123, 16'd120, 16'd118, 16'd115,
		16'd113, 16'd110, 16'd107, 16'd105, 16'd102, 16'd100, 16'd97, 16'd94,
		16'd92, 16'd89, 16'd87, 16'd83, 16'd81, 16'd79, 16'd76, 16'd74,
		16'd70, 16'd68, 16'd66, 16'd63, 16'd61, 16'd57, 16'd55, 16'd52,
		16'd50, 16'd48, 16'd44, 16'd42, 16'd39, 16'd37, 16'd34, 16'd31,
		16'd29, 16'd26, 16'd24, 16'd21, 16'd18, 16'd16, 16'd13, 16'd11,
		16'd8, 16'd6, 16'd3, 16'd2
	};

	localparam logic [15:0] ONE_SUMS [SCAN_STEPS] = '{
		16'd16320, 16'd16315, 16'd15946, 16'd15277, 16'd14655, 16'd14073, 16'd13623,
		16'd13230, 16'd12859, 16'd12560, 16'd12240, 16'd11861, 16'd11456, 16'd11081,
		16'd10714, 16'd10360, 16'd10027, 16'd9679, 16'd9368, 16'd9056, 16'd8680,
		16'd8331, 16'd7995, 16'd7668, 16'd7376, 16'd7084, 16'd6823, 16'd6562,
		16'd6345, 16'd6125, 16'd5939, 16'd5756, 16'd5571, 16'd5421, 16'd5240,
		16'd5086, 16'd4976, 16'd4829, 16'd4719, 16'd4616, 16'd4463, 16'd4393,
		16'd4280, 16'd4166, 16'd4092, 16'd3980, 16'd3909, 16'd3835, 16'd3755,
		16'd3688, 16'd3621, 16'd3541, 16'd3467, 16'd3396, 16'd3323, 16'd3247,
		16'd3170, 16'd3096, 16'd3021, 16'd2952, 16'd2874, 16'd2804, 16'd2727,
		16'd2657, 16'd2583, 16'd2509, 16'd2437, 16'd2362, 16'd2290, 16'd2211,
		16'd2136, 16'd2068, 16'd1996, 16'd1915, 16'd1858, 16'd1773, 16'd1692,
		16'd1620, 16'd1552, 16'd1477, 16'd1398, 16'd1326, 16'd1251, 16'd1179,
		16'd1109, 16'd1031, 16'd961, 16'd884, 16'd814, 16'd736, 16'd667,
		16'd592, 16'd518, 16'd441, 16'd369, 16'd292, 16'd221, 16'd151,
		16'd86, 16'd64
	};

endpackage

`default_nettype wire

// ----- rtl/core/jpeg_quality_estimator_core.sv -----
// Top level of the JPEG quality estimator.
// Instantiates jqe_controller and jqe_datapath; uses jqe_pkg.
//
// The input channel takes one quantization table entry per item: table_number,
// coef_position, coef_value and last_entry. Items without a last mark are taken
// one per cycle while no estimate is running and only update the running sums and table marks.
// An item with the last mark starts an estimate. The input stalls for a
// preparation step and then for the steps of the reference table scan, which
// the scan sequencer runs one table step per cycle; the input stays stalled
// until the result is loaded into the output register.
// When table 0 was never seen the scan ends at its first step.
// The output channel carries quality and two_table_mode from an output register.
// Items keep flowing in while a result waits; a stalled result holds, and the
// next estimate holds in its final step until the output register is free.
// After each result all sums and marks are clear. Reset clears the same state
// and empties the output register; the block is ready in the first cycle after it.
`default_nettype none

module jpeg_quality_estimator_core #(
	parameter int TABLE_SLOTS     = jqe_pkg::TABLE_SLOTS_DEF,
	parameter int COEFS_PER_TABLE = jqe_pkg::COEFS_PER_TABLE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    table_number,
	input  wire logic [5:0]                    coef_position,
	input  wire logic [jqe_pkg::VALUE_W-1:0]   coef_value,
	input  wire logic                          last_entry,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [jqe_pkg::QUALITY_W-1:0]      quality,
	output logic                               two_table_mode
);

	jqe_pkg::cmd_t    cmd;
	jqe_pkg::status_t status;

	jqe_controller u_controller (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last_entry(last_entry),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	jqe_datapath #(
		.TABLE_SLOTS    (TABLE_SLOTS),
		.COEFS_PER_TABLE(COEFS_PER_TABLE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.table_number  (table_number),
		.coef_position (coef_position),
		.coef_value    (coef_value),
		.quality       (quality),
		.two_table_mode(two_table_mode)
	);

endmodule

`default_nettype wire

// ----- rtl/core/jqe_datapath.sv -----
// Datapath of the JPEG quality estimator: sums, probe capture, scan step and result register.
// Driven by the command struct from jqe_controller; uses jqe_pkg.
`default_nettype none

module jqe_datapath #(
	parameter int TABLE_SLOTS     = jqe_pkg::TABLE_SLOTS_DEF,
	parameter int COEFS_PER_TABLE = jqe_pkg::COEFS_PER_TABLE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire jqe_pkg::cmd_t                cmd,
	output jqe_pkg::status_t                  status,
	input  wire logic [1:0]                   table_number,
	input  wire logic [5:0]                   coef_position,
	input  wire logic [jqe_pkg::VALUE_W-1:0]  coef_value,
	output logic [jqe_pkg::QUALITY_W-1:0]     quality,
	output logic                              two_table_mode
);

	localparam int SUM_W   = jqe_pkg::SUM_W;
	localparam int PROBE_W = jqe_pkg::PROBE_W;
	localparam int STEP_W  = jqe_pkg::STEP_W;

	logic [SUM_W-1:0]   entry_sum_q;
	logic [PROBE_W-1:0] luma_probe_sum_q;
	logic [PROBE_W-1:0] chroma_probe_sum_q;
	logic [1:0]         tables_seen_q;
	logic [PROBE_W:0]   probe_q;
	logic               mode_q;
	logic               table0_q;
	logic [STEP_W-1:0]  step_q;
	logic [jqe_pkg::QUALITY_W-1:0] quality_q;
	logic               two_table_mode_q;

	logic [SUM_W:0]     sum_add;
	logic [PROBE_W:0]   luma_add;
	logic [PROBE_W:0]   chroma_add;
	logic               slot_ok;
	logic               luma_hit;
	logic               chroma_hit;
	logic [15:0]        hash_v;
	logic [15:0]        sums_v;
	logic               cont;
	logic               fit;
	logic               at_end;
	logic [jqe_pkg::QUALITY_W-1:0] result;

	always_comb begin
		slot_ok = 32'(table_number) < TABLE_SLOTS;
		luma_hit = (table_number == 2'd0) &&
			((coef_position == 6'(jqe_pkg::LUMA_POS_A)) ||
			 (coef_position == 6'(jqe_pkg::LUMA_POS_B)));
		chroma_hit = (table_number == 2'd1) &&
			((coef_position == 6'(jqe_pkg::CHROMA_POS_A)) ||
			 (coef_position == 6'(COEFS_PER_TABLE - 1)));
		sum_add    = {1'b0, entry_sum_q} + {(SUM_W - jqe_pkg::VALUE_W + 1)'(0), coef_value};
		luma_add   = {1'b0, luma_probe_sum_q} + {2'b00, coef_value};
		chroma_add = {1'b0, chroma_probe_sum_q} + {2'b00, coef_value};
	end

	always_comb begin
		hash_v = mode_q ? jqe_pkg::TWO_HASH[step_q] : jqe_pkg::ONE_HASH[step_q];
		sums_v = mode_q ? jqe_pkg::TWO_SUMS[step_q] : jqe_pkg::ONE_SUMS[step_q];
		cont = (probe_q < {2'b00, hash_v}) && (entry_sum_q < {8'h00, sums_v});
		fit = ((probe_q <= {2'b00, hash_v}) && (entry_sum_q <= {8'h00, sums_v})) ||
			(step_q >= STEP_W'(jqe_pkg::FORCE_STEP));
		at_end = step_q == STEP_W'(jqe_pkg::SCAN_STEPS - 1);
		status.done = !table0_q || !cont || at_end;
		result = '0;
		if (table0_q && !cont && fit) begin
			result = step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_sum_q        <= '0;
			luma_probe_sum_q   <= '0;
			chroma_probe_sum_q <= '0;
			tables_seen_q      <= '0;
		end else if (cmd.load_result) begin
			entry_sum_q        <= '0;
			luma_probe_sum_q   <= '0;
			chroma_probe_sum_q <= '0;
			tables_seen_q      <= '0;
		end else if (cmd.accumulate && slot_ok) begin
			entry_sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
			if (table_number == 2'd0) begin
				tables_seen_q[0] <= 1'b1;
			end
			if (table_number == 2'd1) begin
				tables_seen_q[1] <= 1'b1;
			end
			if (luma_hit) begin
				luma_probe_sum_q <= luma_add[PROBE_W] ? '1 : luma_add[PROBE_W-1:0];
			end
			if (chroma_hit) begin
				chroma_probe_sum_q <= chroma_add[PROBE_W] ? '1 : chroma_add[PROBE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			mode_q   <= 1'b0;
			table0_q <= 1'b0;
		end else if (cmd.prep) begin
			step_q   <= '0;
			mode_q   <= tables_seen_q == 2'b11;
			table0_q <= tables_seen_q[0];
		end else if (cmd.step_inc) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			probe_q <= (tables_seen_q == 2'b11) ?
				{1'b0, luma_probe_sum_q} + {1'b0, chroma_probe_sum_q} :
				{1'b0, luma_probe_sum_q};
		end
		if (cmd.load_result) begin
			quality_q        <= result;
			two_table_mode_q <= mode_q;
		end
	end

	assign quality        = quality_q;
	assign two_table_mode = two_table_mode_q;

endmodule

`default_nettype wire

// ----- rtl/core/jqe_controller.sv -----
// Controller of the JPEG quality estimator: input and output handshake and scan sequencing.
// Issues the command struct to jqe_datapath; uses jqe_pkg.
`default_nettype none

module jqe_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              last_entry,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output jqe_pkg::cmd_t          cmd,
	input  wire jqe_pkg::status_t  status
);

	jqe_pkg::state_t state_q;
	jqe_pkg::state_t state_next;
	logic            out_valid_q;
	logic            out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jqe_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		state_next = state_q;
		in_stall   = 1'b1;
		cmd        = '0;
		unique case (state_q)
			jqe_pkg::ST_IDLE: begin
				in_stall       = 1'b0;
				cmd.accumulate = in_valid;
				if (in_valid && last_entry) begin
					state_next = jqe_pkg::ST_PREP;
				end
			end
			jqe_pkg::ST_PREP: begin
				cmd.prep   = 1'b1;
				state_next = jqe_pkg::ST_SCAN;
			end
			jqe_pkg::ST_SCAN: begin
				if (!status.done) begin
					cmd.step_inc = 1'b1;
				end else if (out_free) begin
					cmd.load_result = 1'b1;
					state_next      = jqe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = jqe_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
